// ===== rtl/mwms_pkg.sv =====
`timescale 1ns / 1ps

package mwms_pkg;

  localparam int MaxWords  = 16;
  localparam int LimbW     = 32;
  localparam int CntW      = $clog2(MaxWords + 1);
  localparam int OpAw      = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int ProdDepth = 32;
  localparam int ProdAw    = $clog2(ProdDepth);
  localparam int LenW      = $clog2(ProdDepth + 1);
  localparam int SumW      = CntW + 1;
  localparam int WideW     = (SumW > LenW) ? SumW : LenW;
  localparam int ColW      = ((ProdAw > CntW) ? ProdAw : CntW) + 1;
  localparam int AccW      = 3 * LimbW;

  // controller to datapath
  typedef struct packed {
    logic              ld_clr;
    logic              mac_valid;
    logic              col_end;
    logic              dbl;
    logic [OpAw-1:0]   addr_a;
    logic [OpAw-1:0]   addr_b;
    logic [ProdAw-1:0] col;
    logic              rd_en;
    logic [ProdAw-1:0] rd_addr;
    logic              rd_last;
    logic              emit_zero;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] first_count;
    logic [CntW-1:0] second_count;
    logic            pipe_busy;
    logic            rd_pend;
    logic            out_free;
    logic [LenW-1:0] len;
  } dp_stat_t;

endpackage

// ===== rtl/mwms_dp.sv =====
`timescale 1ns / 1ps

module mwms_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          square_mode_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          op_i,
  input  logic [mwms_pkg::LimbW-1:0]    word_i,
  input  logic                          last_i,
  input  logic                          empty_req_i,
  input  mwms_pkg::dp_cmd_t             cmd_i,
  output mwms_pkg::dp_stat_t            stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [mwms_pkg::LimbW-1:0]    word_res_o,
  output logic [mwms_pkg::ProdAw-1:0]   index_o,
  output logic                          last_res_o,
  output logic [mwms_pkg::LenW-1:0]     length_o,
  output logic                          overflow_o
);

  typedef struct packed {
    logic                        mac;
    logic                        dbl;
    logic                        ce;
    logic [mwms_pkg::ProdAw-1:0] col;
  } tag_t;

  logic fire, take;
  logic [mwms_pkg::CntW-1:0] fcnt_q, fcnt_d, scnt_q, scnt_d;
  logic fdone_q, fdone_d, sdone_q, sdone_d, ovs_q, ovs_d;
  logic wr_a, wr_b;

  logic [mwms_pkg::LimbW-1:0] mem_a_q [mwms_pkg::MaxWords];
  logic [mwms_pkg::LimbW-1:0] mem_b_q [mwms_pkg::MaxWords];
  logic [mwms_pkg::LimbW-1:0] prod_mem_q [mwms_pkg::ProdDepth];

  logic [mwms_pkg::LimbW-1:0]   a_rd_q, b_rd_q;
  logic [2*mwms_pkg::LimbW-1:0] prod_q;
  tag_t t1_q, t2_q;
  logic [mwms_pkg::AccW-1:0] acc_q, acc_d, addend, sum;
  logic [mwms_pkg::LenW-1:0] len_q, len_d;
  logic ov_q;

  logic [mwms_pkg::LimbW-1:0]  prod_rd_q;
  logic                        rd_pend_q;
  logic [mwms_pkg::ProdAw-1:0] rd_idx_q;
  logic                        rd_last_q;

  logic                        out_valid_q;
  logic [mwms_pkg::LimbW-1:0]  word_res_q;
  logic [mwms_pkg::ProdAw-1:0] index_q;
  logic                        last_res_q;
  logic [mwms_pkg::LenW-1:0]   length_q;
  logic                        overflow_q;

  // operand loading
  assign fire = in_valid_i & in_ready_i;
  assign take = fire & ~(square_mode_i & op_i);

  assign wr_a = take & ~op_i & ~fdone_q & ~empty_req_i &
                (fcnt_q < mwms_pkg::CntW'(mwms_pkg::MaxWords));
  assign wr_b = take & op_i & ~sdone_q & ~empty_req_i &
                (scnt_q < mwms_pkg::CntW'(mwms_pkg::MaxWords));

  always_comb begin
    fcnt_d  = fcnt_q;
    scnt_d  = scnt_q;
    fdone_d = fdone_q;
    sdone_d = sdone_q;
    ovs_d   = ovs_q;
    if (cmd_i.ld_clr) begin
      fcnt_d  = '0;
      scnt_d  = '0;
      fdone_d = 1'b0;
      sdone_d = 1'b0;
      ovs_d   = 1'b0;
    end else if (take && !op_i && !fdone_q) begin
      if (empty_req_i) begin
        fcnt_d  = '0;
        fdone_d = 1'b1;
      end else begin
        if (fcnt_q < mwms_pkg::CntW'(mwms_pkg::MaxWords)) begin
          fcnt_d = fcnt_q + 1'b1;
        end else begin
          ovs_d = 1'b1;
        end
        if (last_i) begin
          fdone_d = 1'b1;
        end
      end
    end else if (take && op_i && !sdone_q) begin
      if (empty_req_i) begin
        scnt_d  = '0;
        sdone_d = 1'b1;
      end else begin
        if (scnt_q < mwms_pkg::CntW'(mwms_pkg::MaxWords)) begin
          scnt_d = scnt_q + 1'b1;
        end else begin
          ovs_d = 1'b1;
        end
        if (last_i) begin
          sdone_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q  <= '0;
      scnt_q  <= '0;
      fdone_q <= 1'b0;
      sdone_q <= 1'b0;
      ovs_q   <= 1'b0;
    end else begin
      fcnt_q  <= fcnt_d;
      scnt_q  <= scnt_d;
      fdone_q <= fdone_d;
      sdone_q <= sdone_d;
      ovs_q   <= ovs_d;
    end
  end

  // operand stores
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a_q[fcnt_q[mwms_pkg::OpAw-1:0]] <= word_i;
    end
    if (wr_b) begin
      mem_b_q[scnt_q[mwms_pkg::OpAw-1:0]] <= word_i;
    end
    a_rd_q <= mem_a_q[cmd_i.addr_a];
    b_rd_q <= square_mode_i ? mem_a_q[cmd_i.addr_b] : mem_b_q[cmd_i.addr_b];
    prod_q <= a_rd_q * b_rd_q;
  end

  // tags follow the operands through read and multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
    end else begin
      t1_q.mac <= cmd_i.mac_valid;
      t1_q.dbl <= cmd_i.dbl;
      t1_q.ce  <= cmd_i.col_end;
      t1_q.col <= cmd_i.col;
      t2_q     <= t1_q;
    end
  end

  // column accumulator
  always_comb begin
    if (!t2_q.mac) begin
      addend = '0;
    end else if (t2_q.dbl) begin
      addend = {{(mwms_pkg::LimbW - 1){1'b0}}, prod_q, 1'b0};
    end else begin
      addend = {{mwms_pkg::LimbW{1'b0}}, prod_q};
    end
    sum   = acc_q + addend;
    acc_d = acc_q;
    len_d = len_q;
    if (cmd_i.ld_clr) begin
      acc_d = '0;
      len_d = '0;
    end else if (t2_q.ce) begin
      acc_d = {{mwms_pkg::LimbW{1'b0}}, sum[mwms_pkg::AccW-1:mwms_pkg::LimbW]};
      if (sum[mwms_pkg::LimbW-1:0] != '0) begin
        len_d = mwms_pkg::LenW'(t2_q.col) + 1'b1;
      end
    end else if (t2_q.mac) begin
      acc_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      len_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      len_q <= len_d;
      if (cmd_i.ld_clr) begin
        ov_q <= ovs_q;
      end
    end
  end

  // product store
  always_ff @(posedge clk_i) begin
    if (t2_q.ce) begin
      prod_mem_q[t2_q.col] <= sum[mwms_pkg::LimbW-1:0];
    end
    if (cmd_i.rd_en) begin
      prod_rd_q <= prod_mem_q[cmd_i.rd_addr];
      rd_idx_q  <= cmd_i.rd_addr;
      rd_last_q <= cmd_i.rd_last;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
      if (rd_pend_q || cmd_i.emit_zero) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      word_res_q <= prod_rd_q;
      index_q    <= rd_idx_q;
      last_res_q <= rd_last_q;
      length_q   <= len_q;
      overflow_q <= ov_q;
    end else if (cmd_i.emit_zero) begin
      word_res_q <= '0;
      index_q    <= '0;
      last_res_q <= 1'b1;
      length_q   <= '0;
      overflow_q <= ov_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_res_o  = word_res_q;
  assign index_o     = index_q;
  assign last_res_o  = last_res_q;
  assign length_o    = length_q;
  assign overflow_o  = overflow_q;

  assign stat_o.start        = fire & fdone_d & (square_mode_i | sdone_d);
  assign stat_o.first_count  = fcnt_q;
  assign stat_o.second_count = scnt_q;
  assign stat_o.pipe_busy    = t1_q.mac | t1_q.ce | t2_q.mac | t2_q.ce;
  assign stat_o.rd_pend      = rd_pend_q;
  assign stat_o.out_free     = ~out_valid_q | out_ready_i;
  assign stat_o.len          = len_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(!out_valid_q || out_ready_i))
    else $error("product word lands on an untaken result");

  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_clr |-> !fire && !stat_o.pipe_busy)
    else $error("operand clear during load or multiply");

  a_zero_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_zero |-> !rd_pend_q && len_q == '0)
    else $error("zero result clashes with product read");

endmodule

// ===== rtl/mwms_ctrl.sv =====
`timescale 1ns / 1ps

module mwms_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          square_mode_i,
  input  logic [mwms_pkg::LenW-1:0]     result_max_words_i,
  input  mwms_pkg::dp_stat_t            stat_i,
  output logic                          in_ready_o,
  output mwms_pkg::dp_cmd_t             cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_COMP  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [mwms_pkg::ProdAw-1:0] k_q, k_d, i_q, i_d, e_q, e_d;
  logic [mwms_pkg::CntW-1:0]   la_q, la_d, lb_q, lb_d;
  logic [mwms_pkg::LenW-1:0]   n_q, n_d;

  logic [mwms_pkg::CntW-1:0]  la_n, lb_n;
  logic [mwms_pkg::WideW-1:0] sum_w, cap_w;
  logic [mwms_pkg::LenW-1:0]  cap;
  logic [mwms_pkg::ColW-1:0]  kx, ix, jx, lax, lbx, nx, iend, knx, st;
  logic                       nonempty, ce;

  assign kx  = mwms_pkg::ColW'(k_q);
  assign ix  = mwms_pkg::ColW'(i_q);
  assign jx  = kx - ix;
  assign lax = mwms_pkg::ColW'(la_q);
  assign lbx = mwms_pkg::ColW'(lb_q);
  assign nx  = mwms_pkg::ColW'(n_q);
  assign knx = kx + 1'b1;

  always_comb begin
    la_n  = stat_i.first_count;
    lb_n  = square_mode_i ? stat_i.first_count : stat_i.second_count;
    cap   = (result_max_words_i > mwms_pkg::LenW'(mwms_pkg::ProdDepth)) ?
            mwms_pkg::LenW'(mwms_pkg::ProdDepth) : result_max_words_i;
    cap_w = mwms_pkg::WideW'(cap);
    if (la_n == '0 || lb_n == '0) begin
      sum_w = '0;
    end else begin
      sum_w = mwms_pkg::WideW'(la_n) + mwms_pkg::WideW'(lb_n);
    end

    // last first-operand index of column k
    iend = (kx < lax - 1'b1) ? kx : lax - 1'b1;
    if (square_mode_i && (kx >> 1) < iend) begin
      iend = kx >> 1;
    end
    nonempty = (ix <= iend);
    ce       = !nonempty || (ix == iend);
    // first index of the next column
    st = (knx >= lbx) ? knx - lbx + 1'b1 : '0;
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    i_d        = i_q;
    e_d        = e_q;
    la_d       = la_q;
    lb_d       = lb_q;
    n_d        = n_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (stat_i.start) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.ld_clr = 1'b1;
        la_d = la_n;
        lb_d = lb_n;
        n_d  = (sum_w > cap_w) ? cap : mwms_pkg::LenW'(sum_w);
        k_d  = '0;
        i_d  = '0;
        e_d  = '0;
        state_d = ((sum_w == '0) || (cap == '0)) ? S_DRAIN : S_COMP;
      end
      S_COMP: begin
        cmd_o.mac_valid = nonempty;
        cmd_o.col_end   = ce;
        cmd_o.dbl       = square_mode_i && (ix != jx);
        cmd_o.addr_a    = ix[mwms_pkg::OpAw-1:0];
        cmd_o.addr_b    = jx[mwms_pkg::OpAw-1:0];
        cmd_o.col       = k_q;
        if (ce) begin
          if (kx == nx - 1'b1) begin
            state_d = S_DRAIN;
          end else begin
            k_d = k_q + 1'b1;
            i_d = st[mwms_pkg::ProdAw-1:0];
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.len == '0) begin
          if (stat_i.out_free && !stat_i.rd_pend) begin
            cmd_o.emit_zero = 1'b1;
            state_d = S_IDLE;
          end
        end else if (stat_i.out_free && !stat_i.rd_pend) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = e_q;
          cmd_o.rd_last = (mwms_pkg::LenW'(e_q) == stat_i.len - 1'b1);
          if (cmd_o.rd_last) begin
            e_d     = '0;
            state_d = S_IDLE;
          end else begin
            e_d = e_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      i_q     <= '0;
      e_q     <= '0;
      la_q    <= '0;
      lb_q    <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      e_q     <= e_d;
      la_q    <= la_d;
      lb_q    <= lb_d;
      n_q     <= n_d;
    end
  end

  a_setup_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SETUP) |-> $past(stat_i.start))
    else $error("setup without a completing transfer");

  a_pair_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac_valid |-> (ix < lax) && (jx < lbx))
    else $error("limb pair outside loaded operands");

  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !stat_i.pipe_busy)
    else $error("emission overlaps accumulation");

endmodule

// ===== rtl/multiword_multiply_square.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                      payload
// input     in         in_valid_i / in_ready_o        op, word, last, empty_req
// result    out        out_valid_o / out_ready_i      word_res, index, last_res, length, overflow
// config    in         psel/penable/pwrite, pready    paddr, pwdata, prdata
//
// an operand word is taken on each handshake; input is held off from the last word until emission
// compute: a setup state, then one multiply-accumulate step per limb pair (one step for a
//   column with no pair), then a drain of the read-multiply-accumulate pipeline
// results: one product word at a time from the registered product store read port
// reset clears control and the column accumulator; limb stores are not cleared
// a stalled result holds in the output register; input reopens once the last word is read

module multiword_multiply_square (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [mwms_pkg::LimbW-1:0]    word_i,
  input  logic                          last_i,
  input  logic                          empty_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mwms_pkg::LimbW-1:0]    word_res_o,
  output logic [mwms_pkg::ProdAw-1:0]   index_o,
  output logic                          last_res_o,
  output logic [mwms_pkg::LenW-1:0]     length_o,
  output logic                          overflow_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                      sq_q;
  logic [mwms_pkg::LenW-1:0] rmw_q;
  logic                      wr_en;
  mwms_pkg::dp_cmd_t         cmd;
  mwms_pkg::dp_stat_t        stat;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q  <= 1'b0;
      rmw_q <= mwms_pkg::LenW'(mwms_pkg::ProdDepth);
    end else if (wr_en) begin
      if (paddr[2]) begin
        rmw_q <= pwdata[mwms_pkg::LenW-1:0];
      end else begin
        sq_q <= pwdata[0];
      end
    end
  end

  assign prdata = paddr[2] ? {{(32 - mwms_pkg::LenW){1'b0}}, rmw_q} : {31'b0, sq_q};

  mwms_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .square_mode_i      (sq_q),
    .result_max_words_i (rmw_q),
    .stat_i             (stat),
    .in_ready_o         (in_ready_o),
    .cmd_o              (cmd)
  );

  mwms_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .square_mode_i (sq_q),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .word_i        (word_i),
    .last_i        (last_i),
    .empty_req_i   (empty_req_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .word_res_o    (word_res_o),
    .index_o       (index_o),
    .last_res_o    (last_res_o),
    .length_o      (length_o),
    .overflow_o    (overflow_o)
  );

endmodule

// ===== tb/multiword_multiply_square_tb.sv =====
`timescale 1ns / 1ps

module multiword_multiply_square_tb;

  localparam bit          OpFirst           = 1'b0;
  localparam bit          OpSecond          = 1'b1;
  localparam int unsigned RegSquareMode     = 0;
  localparam int unsigned RegResultMaxWords = 1;
  localparam int unsigned SettleCycles      = 32;
  localparam int unsigned EndDrain          = 400;
  localparam int unsigned PhaseItems        = 42;

  typedef struct packed {
    logic [mwms_pkg::LimbW-1:0]  limb;
    logic [mwms_pkg::ProdAw-1:0] pos;
    logic                        tail;
    logic [mwms_pkg::LenW-1:0]   len;
    logic                        ovf;
  } prod_limb_t;

  typedef struct packed {
    bit                       op;
    bit [mwms_pkg::LimbW-1:0] limb;
    bit                       tail;
    bit                       empty;
  } load_t;

  class product_scoreboard;
    bit                       square_mode;
    bit [5:0]                 max_words;
    bit [mwms_pkg::LimbW-1:0] a_limbs [mwms_pkg::MaxWords];
    bit [mwms_pkg::LimbW-1:0] b_limbs [mwms_pkg::MaxWords];
    int unsigned              a_cnt;
    int unsigned              b_cnt;
    bit                       a_done;
    bit                       b_done;
    bit                       dropped;
    prod_limb_t               expected_q [$];
    int unsigned              errors;

    function new();
      square_mode = 1'b0;
      max_words   = 6'd32;
      a_cnt       = 0;
      b_cnt       = 0;
      a_done      = 1'b0;
      b_done      = 1'b0;
      dropped     = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(int unsigned idx, bit [31:0] value);
      if (idx == RegSquareMode) begin
        square_mode = value[0];
      end else if (idx == RegResultMaxWords) begin
        max_words = value[5:0];
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // column by column product with a three-word accumulator
    function void form_product();
      bit [95:0]                acc;
      bit [63:0]                p;
      bit [mwms_pkg::LimbW-1:0] cols [mwms_pkg::ProdDepth];
      bit [mwms_pkg::LimbW-1:0] bj;
      int unsigned              la, lb, cap, n, len, k, i, j;
      bit                       ov;
      prod_limb_t               e;
      la  = a_cnt;
      lb  = square_mode ? a_cnt : b_cnt;
      cap = (max_words > mwms_pkg::ProdDepth) ? mwms_pkg::ProdDepth : max_words;
      n   = (la == 0 || lb == 0) ? 0 : la + lb;
      if (n > cap) n = cap;
      acc = '0;
      for (k = 0; k < n; k++) begin
        for (i = 0; i < la && i <= k; i++) begin
          j = k - i;
          if (j < lb && !(square_mode && i > j)) begin
            bj = square_mode ? a_limbs[j] : b_limbs[j];
            p  = 64'(a_limbs[i]) * 64'(bj);
            if (square_mode && i < j) acc += 96'({p, 1'b0});
            else acc += 96'(p);
          end
        end
        cols[k] = acc[31:0];
        acc     = acc >> 32;
      end
      len = n;
      while (len > 0 && cols[len-1] == '0) len--;
      ov      = dropped;
      a_cnt   = 0;
      b_cnt   = 0;
      a_done  = 1'b0;
      b_done  = 1'b0;
      dropped = 1'b0;
      if (len == 0) begin
        e = '{limb: '0, pos: '0, tail: 1'b1, len: '0, ovf: ov};
        expected_q.push_back(e);
      end else begin
        for (k = 0; k < len; k++) begin
          e = '{limb: cols[k], pos: mwms_pkg::ProdAw'(k), tail: (k + 1 == len),
                len: mwms_pkg::LenW'(len), ovf: ov};
          expected_q.push_back(e);
        end
      end
    endfunction

    // returns 1 when the transfer changed operand state
    function bit note_input(bit op, bit [mwms_pkg::LimbW-1:0] limb, bit tail, bit empty);
      bit taken;
      taken = !(square_mode && op == OpSecond) && !((op == OpSecond) ? b_done : a_done);
      if (taken) begin
        if (op == OpSecond) begin
          if (empty) begin
            b_cnt  = 0;
            b_done = 1'b1;
          end else begin
            if (b_cnt < mwms_pkg::MaxWords) begin
              b_limbs[b_cnt] = limb;
              b_cnt++;
            end else begin
              dropped = 1'b1;
            end
            if (tail) b_done = 1'b1;
          end
        end else begin
          if (empty) begin
            a_cnt  = 0;
            a_done = 1'b1;
          end else begin
            if (a_cnt < mwms_pkg::MaxWords) begin
              a_limbs[a_cnt] = limb;
              a_cnt++;
            end else begin
              dropped = 1'b1;
            end
            if (tail) a_done = 1'b1;
          end
        end
      end
      if (a_done && (square_mode || b_done)) form_product();
      return taken;
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [mwms_pkg::LimbW-1:0] limb, logic [mwms_pkg::ProdAw-1:0] pos,
                      logic tail, logic [mwms_pkg::LenW-1:0] len, logic ovf);
      prod_limb_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected product word %h at index %0d", limb, pos));
        return;
      end
      e = expected_q.pop_front();
      if (limb !== e.limb) report($sformatf("word_res %h, want %h", limb, e.limb));
      if (pos !== e.pos) report($sformatf("index %0d, want %0d", pos, e.pos));
      if (tail !== e.tail) report($sformatf("last_res %b, want %b", tail, e.tail));
      if (len !== e.len) report($sformatf("length %0d, want %0d", len, e.len));
      if (ovf !== e.ovf) report($sformatf("overflow %b, want %b", ovf, e.ovf));
    endtask
  endclass

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_valid   = 1'b0;
  logic                        in_ready;
  logic                        op_sel     = 1'b0;
  logic [mwms_pkg::LimbW-1:0]  word       = '0;
  logic                        last_word  = 1'b0;
  logic                        empty_req  = 1'b0;
  logic                        out_valid;
  logic                        out_ready  = 1'b0;
  logic [mwms_pkg::LimbW-1:0]  word_res;
  logic [mwms_pkg::ProdAw-1:0] res_index;
  logic                        last_res;
  logic [mwms_pkg::LenW-1:0]   res_length;
  logic                        overflow;
  logic                        psel       = 1'b0;
  logic                        penable    = 1'b0;
  logic                        pwrite     = 1'b0;
  logic [2:0]                  paddr      = '0;
  logic [31:0]                 pwdata     = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  bit                calm_phase = 1'b0;
  product_scoreboard sb;

  multiword_multiply_square i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op_sel),
    .word_i      (word),
    .last_i      (last_word),
    .empty_req_i (empty_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .word_res_o  (word_res),
    .index_o     (res_index),
    .last_res_o  (last_res),
    .length_o    (res_length),
    .overflow_o  (overflow),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [mwms_pkg::LimbW-1:0] rand_limb();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 75) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, mwms_pkg::MaxWords);
    return $urandom_range(mwms_pkg::MaxWords + 1, mwms_pkg::MaxWords + 2);
  endfunction

  // one input transfer; valid stays high afterwards unless the next call idles
  task automatic send_load(input bit op, input bit [mwms_pkg::LimbW-1:0] limb,
                           input bit tail, input bit empty, output bit taken);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op_sel    <= op;
    word      <= limb;
    last_word <= tail;
    empty_req <= empty;
    do @(posedge clk); while (!in_ready);
    taken = sb.note_input(op, limb, tail, empty);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input int unsigned idx, input bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void fill_operand(bit op, int unsigned len, ref load_t q [$]);
    load_t it;
    q.delete();
    if (len == 0) begin
      it = '{op: op, limb: $urandom, tail: 1'($urandom), empty: 1'b1};
      q.push_back(it);
    end else begin
      for (int unsigned k = 0; k < len; k++) begin
        it = '{op: op, limb: rand_limb(), tail: (k + 1 == len), empty: 1'b0};
        q.push_back(it);
      end
    end
  endfunction

  // mostly whole operations with interleaved operand transfers, some stray transfers
  task automatic random_phase(input int unsigned target);
    int unsigned count;
    load_t       qa [$];
    load_t       qb [$];
    load_t       it;
    bit          taken;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 99) < 85) begin
        fill_operand(OpFirst, pick_len(), qa);
        if (!sb.square_mode) fill_operand(OpSecond, pick_len(), qb);
        else if ($urandom_range(0, 9) == 0) fill_operand(OpSecond, 1, qb);
        else qb.delete();
        while (qa.size() != 0 || qb.size() != 0) begin
          if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 0))
            it = qa.pop_front();
          else
            it = qb.pop_front();
          send_load(it.op, it.limb, it.tail, it.empty, taken);
          if (taken) count++;
        end
      end else begin
        send_load(1'($urandom), rand_limb(), 1'($urandom), ($urandom_range(0, 9) == 0), taken);
        if (taken) count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(word_res, res_index, last_res, res_length, overflow);
  end

  initial begin
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat (calm_phase ? 8 : $urandom_range(1, 12)) @(posedge clk);
      if (!calm_phase) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    #(64'd20_000_000);
    $display("multiword_multiply_square regression: fail");
    $finish;
  end

  initial begin
    bit          taken;
    int unsigned k;
    bit [5:0]    cap;
    bit          modes [10];
    bit [5:0]    caps  [10];
    bit          calms [10];
    sb    = new();
    modes = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    caps  = '{6'd32, 6'd32, 6'd1, 6'd1, 6'd0, 6'd63, 6'd33, 6'd0, 6'd0, 6'd32};
    calms = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // all-ones single words
    send_load(OpFirst, '1, 1'b1, 1'b0, taken);
    send_load(OpSecond, '1, 1'b1, 1'b0, taken);
    // empty request drops a loaded word, then a completed operand ignores more
    send_load(OpFirst, 32'h0000_0001, 1'b0, 1'b0, taken);
    send_load(OpFirst, '1, 1'b1, 1'b1, taken);
    send_load(OpFirst, '1, 1'b1, 1'b0, taken);
    send_load(OpSecond, 32'h8000_0000, 1'b1, 1'b0, taken);
    // zero limbs give a zero product
    send_load(OpSecond, '0, 1'b1, 1'b0, taken);
    send_load(OpFirst, '0, 1'b1, 1'b0, taken);
    // a mode change completes a pending operation on the next transfer
    send_load(OpFirst, 32'hdead_beef, 1'b1, 1'b0, taken);
    idle_input();
    settle();
    cfg_write(RegSquareMode, 32'd1);
    send_load(OpSecond, 32'h5555_5555, 1'b1, 1'b0, taken);
    // square with one word too many
    for (k = 0; k < mwms_pkg::MaxWords; k++)
      send_load(OpFirst, (k % 2) ? '1 : $urandom, 1'b0, 1'b0, taken);
    send_load(OpFirst, 32'h1234_5678, 1'b1, 1'b0, taken);

    for (k = 0; k < 10; k++) begin
      idle_input();
      settle();
      cap = (k == 7 || k == 8) ? 6'($urandom_range(2, 31)) : caps[k];
      cfg_write(RegSquareMode, 32'(modes[k]));
      cfg_write(RegResultMaxWords, 32'(cap));
      calm_phase = calms[k];
      random_phase(PhaseItems);
    end

    idle_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (EndDrain) @(posedge clk);
    if (sb.errors == 0) begin
      $display("multiword_multiply_square regression: pass");
    end else begin
      $display("multiword_multiply_square regression: fail");
    end
    $finish;
  end

endmodule
